// ===== rtl/bba_pkg.sv =====
// shared types and constants for the bitmap block allocator
// used by the controller, the datapath and the top level; no dependencies
package bba_pkg;

  localparam int WORD_BITS = 32;
  // block index and divider width: holds start + length + block size - 1 in every mode
  localparam int DIVW = 34;

  typedef enum logic [1:0] {
    MODE_MARK_FREE = 2'd0,
    MODE_MARK_USED = 2'd1,
    MODE_ALLOC     = 2'd2,
    MODE_FREE      = 2'd3
  } mode_t;

  typedef enum logic [4:0] {
    OP_NOP,
    OP_CLR,
    OP_LOAD,
    OP_LD_A,
    OP_LD_B,
    OP_STEP,
    OP_SAVE_A,
    OP_SAVE_B,
    OP_SETUP,
    OP_MRD,
    OP_MWR,
    OP_SRD,
    OP_SZERO,
    OP_SBIT,
    OP_FOUND,
    OP_NOFIT,
    OP_OUT
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } dp_cmd_t;

  typedef struct packed {
    mode_t mode;
    logic  div_last;
    logic  range_empty;
    logic  mark_last;
    logic  map_last;
    logic  word_zero;
    logic  bit_last;
    logic  hit;
  } dp_stat_t;

endpackage

// ===== rtl/bba_map_ram.sv =====
// bitmap storage: one write port, one registered read port
// no package dependencies
module bba_map_ram #(
  parameter int DEPTH = 1024,
  parameter int AW    = 10
) (
  input  logic          clk,
  input  logic          we,
  input  logic [AW-1:0] waddr,
  input  logic [31:0]   wdata,
  input  logic          re,
  input  logic [AW-1:0] raddr,
  output logic [31:0]   rdata
);

  logic [31:0] mem [DEPTH];

  // write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== rtl/bba_datapath.sv =====
// allocator datapath: request registers, reciprocal divider, word masking, bit scan
// depends on bba_pkg and bba_map_ram
module bba_datapath #(
  parameter int MAP_WORDS   = 1024,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  bba_pkg::dp_cmd_t cmd,
  output bba_pkg::dp_stat_t stat,
  input  logic [1:0]       in_mode,
  input  logic [31:0]      in_start_address,
  input  logic [31:0]      in_length,
  output logic             out_status,
  output logic [31:0]      out_block_address
);
  import bba_pkg::*;

  localparam int AW = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW = AW + 5;
  localparam int CW = 2;
  localparam int RS = 48;
  localparam logic [DIVW-1:0] TOTAL = DIVW'(MAP_WORDS * WORD_BITS);
  localparam logic [DIVW-1:0] BB_M1 = DIVW'(BLOCK_BYTES - 1);
  localparam logic [DIVW-1:0] BB_X  = DIVW'(BLOCK_BYTES);
  localparam logic [39:0] RECIP = 40'((64'd1 << RS) / 64'(BLOCK_BYTES));
  localparam logic [19:0] RECIP_LO = RECIP[19:0];
  localparam logic [19:0] RECIP_HI = RECIP[39:20];
  localparam logic [AW-1:0] LAST_W = AW'(MAP_WORDS - 1);
  localparam logic [CW-1:0] LAST_STEP = CW'(2);

  mode_t           mode_r;
  logic [31:0]     start_r, len_r;
  logic [DIVW-1:0] dividend_r, quo_r, first_r, last_r;
  logic [53:0]     prod_r;
  logic [CW-1:0]   cnt_r;
  logic [AW-1:0]   w_r;
  logic [4:0]      bit_r;
  logic [31:0]     run_len_r;
  logic [BW-1:0]   run_start_r;
  logic            status_r, out_status_r;
  logic [31:0]     addr_r, out_addr_r;
  logic [31:0]     rdata;

  // division by the block size: reciprocal product in two halves, then one correction
  logic [19:0]     mul_b;
  logic [53:0]     mul_p;
  logic [54:0]     acc;
  logic [DIVW-1:0] qbb, rem_x;
  logic            ge;
  assign mul_b = (cnt_r == '0) ? RECIP_LO : RECIP_HI;
  assign mul_p = 54'(dividend_r) * 54'(mul_b);
  assign acc   = {1'b0, mul_p} + {21'd0, prod_r[53:20]};
  assign qbb   = DIVW'(quo_r[26:0]) * BB_X;
  assign rem_x = dividend_r - qbb;
  assign ge    = rem_x >= BB_X;

  // dividends for the two region ends
  logic [DIVW-1:0] start_x, sum_x, div_a, div_b;
  assign start_x = {2'b00, start_r};
  assign sum_x   = start_x + {2'b00, len_r};
  assign div_a   = (mode_r == MODE_MARK_FREE) ? start_x + BB_M1 : start_x;
  assign div_b   = (mode_r == MODE_MARK_USED) ? sum_x + BB_M1 : sum_x;

  // end of range for setup, clamped to the map
  logic [DIVW-1:0] lst, lst_c;
  assign lst   = (mode_r == MODE_FREE) ? first_r + {2'b00, len_r} : last_r;
  assign lst_c = (lst > TOTAL) ? TOTAL : lst;

  // word mask for the range
  logic [DIVW-1:0] lm1;
  logic [AW-1:0]   fw, lw;
  logic [4:0]      lo, hi;
  logic [31:0]     mask, new_word;
  logic            make_free;
  assign lm1       = last_r - 1'b1;
  assign fw        = first_r[AW+4:5];
  assign lw        = lm1[AW+4:5];
  assign lo        = (w_r == fw) ? first_r[4:0] : 5'd0;
  assign hi        = (w_r == lw) ? lm1[4:0] : 5'd31;
  assign mask      = ({32{1'b1}} << lo) & ({32{1'b1}} >> (5'd31 - hi));
  assign make_free = (mode_r == MODE_MARK_FREE) || (mode_r == MODE_FREE);
  assign new_word  = make_free ? (rdata | mask) : (rdata & ~mask);

  // bit scan
  logic          bit_free;
  logic [BW-1:0] here, start_sel;
  logic [31:0]   prod;
  assign bit_free  = rdata[bit_r];
  assign here      = {w_r, bit_r};
  assign start_sel = (run_len_r == 32'd0) ? here : run_start_r;
  assign prod      = 32'(start_sel) * 32'(BLOCK_BYTES);

  // status to the controller
  assign stat.mode        = mode_r;
  assign stat.div_last    = cnt_r == LAST_STEP;
  assign stat.range_empty = first_r >= last_r;
  assign stat.mark_last   = w_r == lw;
  assign stat.map_last    = w_r == LAST_W;
  assign stat.word_zero   = rdata == 32'd0;
  assign stat.bit_last    = bit_r == 5'd31;
  assign stat.hit         = bit_free && ((run_len_r + 32'd1) == len_r);

  // map memory
  logic        we, re;
  logic [31:0] wdata;
  assign we    = (cmd.op == OP_CLR) || (cmd.op == OP_MWR);
  assign re    = (cmd.op == OP_MRD) || (cmd.op == OP_SRD);
  assign wdata = (cmd.op == OP_CLR) ? 32'd0 : new_word;

  bba_map_ram #(.DEPTH(MAP_WORDS), .AW(AW)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (w_r),
    .wdata (wdata),
    .re    (re),
    .raddr (w_r),
    .rdata (rdata)
  );

  // word pointer and scan counters
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_r       <= '0;
      bit_r     <= '0;
      run_len_r <= '0;
      cnt_r     <= '0;
    end else begin
      case (cmd.op)
        OP_CLR, OP_MWR, OP_SZERO: w_r <= w_r + 1'b1;
        OP_LOAD: begin
          w_r       <= '0;
          run_len_r <= '0;
        end
        OP_LD_A, OP_LD_B: cnt_r <= '0;
        OP_STEP:          cnt_r <= cnt_r + 1'b1;
        OP_SETUP:         w_r <= fw;
        OP_SRD:           bit_r <= '0;
        OP_SBIT: begin
          run_len_r <= bit_free ? run_len_r + 32'd1 : 32'd0;
          bit_r     <= bit_r + 5'd1;
          if (bit_r == 5'd31) begin
            w_r <= w_r + 1'b1;
          end
        end
        default: ;
      endcase
      if (cmd.op == OP_SZERO) begin
        run_len_r <= '0;
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    case (cmd.op)
      OP_LOAD: begin
        mode_r   <= mode_t'(in_mode);
        start_r  <= in_start_address;
        len_r    <= in_length;
        status_r <= 1'b0;
        addr_r   <= '0;
      end
      OP_LD_A: dividend_r <= div_a;
      OP_LD_B: dividend_r <= div_b;
      OP_STEP: begin
        if (cnt_r == '0) begin
          prod_r <= mul_p;
        end else if (cnt_r == CW'(1)) begin
          quo_r <= DIVW'(acc[54:28]);
        end else begin
          quo_r <= quo_r + DIVW'(ge);
        end
      end
      OP_SAVE_A: first_r <= quo_r;
      OP_SAVE_B: last_r  <= quo_r;
      OP_SETUP:  last_r  <= lst_c;
      OP_SBIT: begin
        if (bit_free && run_len_r == 32'd0) begin
          run_start_r <= here;
        end
      end
      OP_FOUND: begin
        first_r <= DIVW'(start_sel);
        last_r  <= DIVW'(start_sel) + {2'b00, len_r};
        addr_r  <= prod;
      end
      OP_NOFIT: status_r <= 1'b1;
      OP_OUT: begin
        out_status_r <= status_r;
        out_addr_r   <= addr_r;
      end
      default: ;
    endcase
  end

  assign out_status        = out_status_r;
  assign out_block_address = out_addr_r;

endmodule

// ===== rtl/bba_ctrl.sv =====
// allocator controller: sequences clearing, division, marking and scanning
// depends on bba_pkg
module bba_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic [1:0]        in_mode,
  input  logic [31:0]       in_length,
  output logic              out_valid,
  input  logic              out_ready,
  output bba_pkg::dp_cmd_t  cmd,
  input  bba_pkg::dp_stat_t stat
);
  import bba_pkg::*;

  typedef enum logic [4:0] {
    S_CLR, S_IDLE, S_DIVA_LD, S_DIVA, S_SAVE_A, S_DIVB_LD, S_DIVB, S_SAVE_B,
    S_SETUP, S_CHK, S_MRD, S_MWR, S_SRD, S_SCHK, S_SBIT, S_FOUND, S_NOFIT, S_FIN
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  assign in_ready  = state_r == S_IDLE;
  assign out_valid = out_valid_r;

  // next state and datapath command
  always_comb begin
    state_nxt     = state_r;
    cmd.op        = OP_NOP;
    out_valid_nxt = out_valid_r && !out_ready;
    case (state_r)
      S_CLR: begin
        cmd.op = OP_CLR;
        if (stat.map_last) begin
          state_nxt = S_IDLE;
        end
      end
      S_IDLE: begin
        if (in_valid) begin
          cmd.op = OP_LOAD;
          if (mode_t'(in_mode) != MODE_ALLOC) begin
            state_nxt = S_DIVA_LD;
          end else if (in_length == 32'd0) begin
            state_nxt = S_FIN;
          end else begin
            state_nxt = S_SRD;
          end
        end
      end
      S_DIVA_LD: begin
        cmd.op    = OP_LD_A;
        state_nxt = S_DIVA;
      end
      S_DIVA: begin
        cmd.op = OP_STEP;
        if (stat.div_last) begin
          state_nxt = S_SAVE_A;
        end
      end
      S_SAVE_A: begin
        cmd.op    = OP_SAVE_A;
        state_nxt = (stat.mode == MODE_FREE) ? S_SETUP : S_DIVB_LD;
      end
      S_DIVB_LD: begin
        cmd.op    = OP_LD_B;
        state_nxt = S_DIVB;
      end
      S_DIVB: begin
        cmd.op = OP_STEP;
        if (stat.div_last) begin
          state_nxt = S_SAVE_B;
        end
      end
      S_SAVE_B: begin
        cmd.op    = OP_SAVE_B;
        state_nxt = S_SETUP;
      end
      S_SETUP: begin
        cmd.op    = OP_SETUP;
        state_nxt = S_CHK;
      end
      S_CHK: begin
        state_nxt = stat.range_empty ? S_FIN : S_MRD;
      end
      S_MRD: begin
        cmd.op    = OP_MRD;
        state_nxt = S_MWR;
      end
      S_MWR: begin
        cmd.op    = OP_MWR;
        state_nxt = stat.mark_last ? S_FIN : S_MRD;
      end
      S_SRD: begin
        cmd.op    = OP_SRD;
        state_nxt = S_SCHK;
      end
      S_SCHK: begin
        if (stat.word_zero) begin
          cmd.op    = OP_SZERO;
          state_nxt = stat.map_last ? S_NOFIT : S_SRD;
        end else begin
          state_nxt = S_SBIT;
        end
      end
      S_SBIT: begin
        if (stat.hit) begin
          state_nxt = S_FOUND;
        end else begin
          cmd.op = OP_SBIT;
          if (stat.bit_last) begin
            state_nxt = stat.map_last ? S_NOFIT : S_SRD;
          end
        end
      end
      S_FOUND: begin
        cmd.op    = OP_FOUND;
        state_nxt = S_SETUP;
      end
      S_NOFIT: begin
        cmd.op    = OP_NOFIT;
        state_nxt = S_FIN;
      end
      S_FIN: begin
        // wait for the output register to free up
        if (!out_valid_r || out_ready) begin
          cmd.op        = OP_OUT;
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // state and output valid
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

endmodule

// ===== rtl/bitmap_block_allocator_unit.sv =====
// bitmap first-fit block allocator, top level: controller plus datapath
// operation: region marking divides each region end by the block size in 3 steps, then
// marks each touched word with a read and a write; block freeing divides only the region
// start; allocation skips all-used words whole, scans mixed words bit by bit, then marks
// the run; a zero-length allocation goes straight to the result, which waits for the output register
// one transaction at a time; the next request is taken while a result waits
// reset: a clearing pass writes every map word all-used; no input taken meanwhile
module bitmap_block_allocator_unit #(
  parameter int MAP_WORDS   = 1024,
  parameter int BLOCK_BYTES = 4096
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_mode,
  input  logic [31:0] in_start_address,
  input  logic [31:0] in_length,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        out_status,
  output logic [31:0] out_block_address
);
  import bba_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer
  bba_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_mode   (in_mode),
    .in_length (in_length),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .cmd       (cmd),
    .stat      (stat)
  );

  // map and arithmetic
  bba_datapath #(.MAP_WORDS(MAP_WORDS), .BLOCK_BYTES(BLOCK_BYTES)) u_dp (
    .clk               (clk),
    .rst_n             (rst_n),
    .cmd               (cmd),
    .stat              (stat),
    .in_mode           (in_mode),
    .in_start_address  (in_start_address),
    .in_length         (in_length),
    .out_status        (out_status),
    .out_block_address (out_block_address)
  );

endmodule
